// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the dendrogram merge builder.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DMB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define DMB_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define DMB_ASSERT(lbl, clk, rst_n, prop)
`define DMB_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ----- src/dmb_pkg.sv -----
// Package for the dendrogram merge builder: controller states and fixed widths.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package dmb_pkg;

    localparam int ID_W   = 10;
    localparam int SIZE_W = 11;
    localparam int CFG_W  = 11;

    localparam logic [SIZE_W-1:0] SIZE_SAT = '1;
    localparam logic [CFG_W-1:0]  LEAF_COUNT_RST = 11'd1024;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_RDA,
        ST_RDB,
        ST_CHK,
        ST_SZB,
        ST_SUM,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

// ----- src/dmb_ram.sv -----
// Single-port-write, single-port-read synchronous memory with registered read data.
// Stands alone; used by the top level for the leaf labels and the merge sizes.
`timescale 1ns / 1ps

module dmb_ram #(
    parameter int ADDR_W = 10,
    parameter int WIDTH  = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/dendrogram_merge_builder_top.sv -----
// Sequencing: an out-of-range word goes from acceptance straight to the result state; an edge inside one
// cluster first reads both leaf labels (RDA, RDB, CHK); a merge also reads both sizes (SZB), sums
// them (SUM) and relabels in a scan (SCAN) over the label memory read port for the leaves below
// bound, bound being min(leaf_count, MAX_LEAVES). Throughput: one word at a time; the next is
// taken once the result is registered, which waits while a held result is stalled.
// Reset: synchronous, active low; afterwards a clearing pass over every label memory address
// empties the label memory while input is stalled. Configuration writes are taken at any time.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dendrogram_merge_builder_top #(
    parameter int MAX_LEAVES = 1024,
    parameter int MAX_MERGES = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [dmb_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [9:0]                i_leaf_a,
    input  logic [9:0]                i_leaf_b,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [dmb_pkg::ID_W-1:0]  o_merge_number,
    output logic                      o_left_is_leaf,
    output logic [dmb_pkg::ID_W-1:0]  o_left_id,
    output logic                      o_right_is_leaf,
    output logic [dmb_pkg::ID_W-1:0]  o_right_id,
    output logic [dmb_pkg::SIZE_W-1:0] o_cluster_size,
    output logic                      o_skipped
);

    import dmb_pkg::*;

    localparam int LW    = $clog2(MAX_LEAVES);
    localparam int LBL_W = (MAX_MERGES > 1) ? $clog2(MAX_MERGES) : 1;
    localparam int ENT_W = LBL_W + 1;
    localparam int CNT_W = $clog2(MAX_MERGES + 1);
    localparam int NB_W  = $clog2(MAX_LEAVES + 1);
    localparam int BW    = (NB_W > CFG_W) ? NB_W : CFG_W;

    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_leaf_count;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [BW-1:0]       r_k, n_k;
    logic [LW-1:0]       r_wk, n_wk;
    logic                r_pend, n_pend;
    logic [LW-1:0]       r_a, n_a;
    logic [LW-1:0]       r_b, n_b;
    logic                r_va, n_va;
    logic [LBL_W-1:0]    r_la, n_la;
    logic                r_vb, n_vb;
    logic [LBL_W-1:0]    r_lb, n_lb;
    logic [SIZE_W-1:0]   r_sa, n_sa;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic                r_skip, n_skip;
    logic                r_out_valid, n_out_valid;
    logic                r_out_load;

    logic [ID_W-1:0]     r_merge_number, r_left_id, r_right_id;
    logic                r_left_is_leaf, r_right_is_leaf, r_skipped;
    logic [SIZE_W-1:0]   r_cluster_size;

    logic                lbl_we;
    logic [LW-1:0]       lbl_waddr, lbl_raddr;
    logic [ENT_W-1:0]    lbl_wdata, lbl_rdata;
    logic                sz_we;
    logic [LBL_W-1:0]    sz_raddr;
    logic [SIZE_W-1:0]   sz_rdata;

    logic [BW-1:0]       bound, a_ext, b_ext;
    logic                full, bad_edge, accept;
    logic                rd_v;
    logic [LBL_W-1:0]    rd_l;
    logic [SIZE_W-1:0]   sb;
    logic [SIZE_W:0]     sum;
    logic                scan_hit;

    dmb_ram #(.ADDR_W(LW), .WIDTH(ENT_W)) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (lbl_we),
        .i_waddr (lbl_waddr),
        .i_wdata (lbl_wdata),
        .i_raddr (lbl_raddr),
        .o_rdata (lbl_rdata)
    );

    dmb_ram #(.ADDR_W(LBL_W), .WIDTH(SIZE_W)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (sz_we),
        .i_waddr (r_cnt[LBL_W-1:0]),
        .i_wdata (n_size),
        .i_raddr (sz_raddr),
        .o_rdata (sz_rdata)
    );

    assign bound = (BW'(r_leaf_count) > BW'(MAX_LEAVES)) ? BW'(MAX_LEAVES)
                                                          : BW'(r_leaf_count);
    assign a_ext    = BW'(i_leaf_a);
    assign b_ext    = BW'(i_leaf_b);
    assign full     = (r_cnt >= CNT_W'(MAX_MERGES));
    assign bad_edge = (a_ext >= bound) || (b_ext >= bound) || (i_leaf_a == i_leaf_b) || full;
    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);

    assign rd_v = lbl_rdata[LBL_W];
    assign rd_l = lbl_rdata[LBL_W-1:0];
    assign sb   = r_vb ? sz_rdata : SIZE_W'(1);
    assign sum  = {1'b0, r_sa} + {1'b0, sb};
    assign scan_hit = (r_wk == r_a) || (r_wk == r_b) ||
                      (rd_v && ((r_va && (rd_l == r_la)) || (r_vb && (rd_l == r_lb))));

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_wk        = r_wk;
        n_pend      = 1'b0;
        n_a         = r_a;
        n_b         = r_b;
        n_va        = r_va;
        n_la        = r_la;
        n_vb        = r_vb;
        n_lb        = r_lb;
        n_sa        = r_sa;
        n_size      = r_size;
        n_skip      = r_skip;
        lbl_we      = 1'b0;
        lbl_waddr   = r_k[LW-1:0];
        lbl_wdata   = '0;
        lbl_raddr   = r_k[LW-1:0];
        sz_we       = 1'b0;
        sz_raddr    = r_la;
        r_out_load  = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            ST_CLR: begin
                lbl_we = 1'b1;
                n_k    = r_k + BW'(1);
                if (r_k[LW-1:0] == '1) begin
                    n_k     = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_a    = a_ext[LW-1:0];
                    n_b    = b_ext[LW-1:0];
                    n_skip = bad_edge;
                    n_state = bad_edge ? ST_DONE : ST_RDA;
                end
            end
            ST_RDA: begin
                lbl_raddr = r_a;
                n_state   = ST_RDB;
            end
            ST_RDB: begin
                lbl_raddr = r_b;
                n_va      = rd_v;
                n_la      = rd_l;
                n_state   = ST_CHK;
            end
            ST_CHK: begin
                n_vb     = rd_v;
                n_lb     = rd_l;
                sz_raddr = r_la;
                if (r_va && rd_v && (r_la == rd_l)) begin
                    n_skip  = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SZB;
                end
            end
            ST_SZB: begin
                sz_raddr = r_lb;
                n_sa     = r_va ? sz_rdata : SIZE_W'(1);
                n_state  = ST_SUM;
            end
            ST_SUM: begin
                n_size  = sum[SIZE_W] ? SIZE_SAT : sum[SIZE_W-1:0];
                sz_we   = 1'b1;
                n_k     = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                lbl_raddr = r_k[LW-1:0];
                if (r_k < bound) begin
                    n_pend = 1'b1;
                    n_wk   = r_k[LW-1:0];
                    n_k    = r_k + BW'(1);
                end
                if (r_pend && scan_hit) begin
                    lbl_we    = 1'b1;
                    lbl_waddr = r_wk;
                    lbl_wdata = {1'b1, LBL_W'(r_cnt)};
                end
                if (!(r_k < bound) && !r_pend) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    r_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    if (!r_skip) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLR;
            r_leaf_count <= LEAF_COUNT_RST;
            r_cnt        <= '0;
            r_k          <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_k         <= n_k;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_leaf_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wk   <= n_wk;
        r_a    <= n_a;
        r_b    <= n_b;
        r_va   <= n_va;
        r_la   <= n_la;
        r_vb   <= n_vb;
        r_lb   <= n_lb;
        r_sa   <= n_sa;
        r_size <= n_size;
        r_skip <= n_skip;
        if (r_out_load) begin
            r_skipped       <= r_skip;
            r_merge_number  <= r_skip ? '0 : ID_W'(r_cnt);
            r_left_is_leaf  <= !r_skip && !r_va;
            r_left_id       <= r_skip ? '0 : (r_va ? ID_W'(r_la) : ID_W'(r_a));
            r_right_is_leaf <= !r_skip && !r_vb;
            r_right_id      <= r_skip ? '0 : (r_vb ? ID_W'(r_lb) : ID_W'(r_b));
            r_cluster_size  <= r_skip ? '0 : r_size;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_merge_number  = r_merge_number;
    assign o_left_is_leaf  = r_left_is_leaf;
    assign o_left_id       = r_left_id;
    assign o_right_is_leaf = r_right_is_leaf;
    assign o_right_id      = r_right_id;
    assign o_cluster_size  = r_cluster_size;
    assign o_skipped       = r_skipped;

    `DMB_ASSERT(a_skip_zero_size, i_clk, i_rst_n, (o_out_valid && o_skipped) |-> (o_cluster_size == '0))
    `DMB_ASSERT(a_merge_size_min, i_clk, i_rst_n, (o_out_valid && !o_skipped) |-> (o_cluster_size >= SIZE_W'(2)))
    `DMB_ASSERT(a_counter_holds, i_clk, i_rst_n, (r_state != ST_DONE) |=> $stable(r_cnt))
    `DMB_NEVER(a_scan_overrun, i_clk, i_rst_n, (r_state == ST_SCAN) && (r_k > bound))

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for dendrogram_merge_builder_top: edge words go in with random gaps
// and output stalls, and a scoreboard class predicts and checks every merge result word.
// Depends on dmb_pkg and the RTL of the block.

localparam int LEAF_SLOTS  = 1024;
localparam int MERGE_SLOTS = 1024;

typedef struct packed {
    logic [dmb_pkg::ID_W-1:0]   merge_number;
    logic                       left_is_leaf;
    logic [dmb_pkg::ID_W-1:0]   left_id;
    logic                       right_is_leaf;
    logic [dmb_pkg::ID_W-1:0]   right_id;
    logic [dmb_pkg::SIZE_W-1:0] cluster_size;
    logic                       skipped;
} t_merge_word;

class merge_scoreboard;
    bit                         leaf_known[LEAF_SLOTS];
    logic [dmb_pkg::SIZE_W-1:0] leaf_owner[LEAF_SLOTS];
    logic [dmb_pkg::SIZE_W-1:0] merge_sizes[MERGE_SLOTS];
    logic [dmb_pkg::SIZE_W-1:0] merge_count;
    int                         leaf_limit;
    t_merge_word                awaited[$];
    int                         words_checked;
    int                         errors;

    function new();
        foreach (leaf_known[k]) begin
            leaf_known[k] = 1'b0;
            leaf_owner[k] = '0;
        end
        foreach (merge_sizes[k]) begin
            merge_sizes[k] = '0;
        end
        merge_count   = '0;
        leaf_limit    = dmb_pkg::LEAF_COUNT_RST;
        words_checked = 0;
        errors        = 0;
    endfunction

    function void note_edge(logic [9:0] a, logic [9:0] b);
        int                         bound;
        int                         total;
        bit                         va;
        bit                         vb;
        logic [dmb_pkg::SIZE_W-1:0] la;
        logic [dmb_pkg::SIZE_W-1:0] lb;
        t_merge_word                w;
        bound = (leaf_limit > LEAF_SLOTS) ? LEAF_SLOTS : leaf_limit;
        w  = '0;
        va = leaf_known[a];
        vb = leaf_known[b];
        la = leaf_owner[a];
        lb = leaf_owner[b];
        if (a >= bound || b >= bound || a == b || merge_count >= MERGE_SLOTS ||
            (va && vb && la == lb)) begin
            w.skipped = 1'b1;
        end else begin
            total = (va ? int'(merge_sizes[la]) : 1) + (vb ? int'(merge_sizes[lb]) : 1);
            if (total > int'(dmb_pkg::SIZE_SAT)) begin
                total = int'(dmb_pkg::SIZE_SAT);
            end
            merge_sizes[merge_count] = total[dmb_pkg::SIZE_W-1:0];
            // Only leaves below the current bound are relabelled; the rest keep stale labels.
            for (int k = 0; k < bound; k++) begin
                if (k == a || k == b || (leaf_known[k] &&
                    ((va && leaf_owner[k] == la) || (vb && leaf_owner[k] == lb)))) begin
                    leaf_known[k] = 1'b1;
                    leaf_owner[k] = merge_count;
                end
            end
            w.merge_number  = merge_count[dmb_pkg::ID_W-1:0];
            w.left_is_leaf  = !va;
            w.left_id       = va ? la[dmb_pkg::ID_W-1:0] : a;
            w.right_is_leaf = !vb;
            w.right_id      = vb ? lb[dmb_pkg::ID_W-1:0] : b;
            w.cluster_size  = total[dmb_pkg::SIZE_W-1:0];
            merge_count     = merge_count + 1'b1;
        end
        awaited.push_back(w);
    endfunction

    function int first_leaf_apart();
        for (int k = 1; k < LEAF_SLOTS; k++) begin
            if (!(leaf_known[0] && leaf_known[k] && leaf_owner[0] == leaf_owner[k])) begin
                return k;
            end
        end
        return -1;
    endfunction

    task report_mismatch(string msg);
        errors++;
        if (errors <= 100) begin
            $display("ERROR: %s", msg);
        end
    endtask

    task check_word(t_merge_word got);
        t_merge_word want;
        string       diffs;
        diffs = "";
        words_checked++;
        if (awaited.size() == 0) begin
            report_mismatch($sformatf("result word %0d arrived with nothing awaited: %h",
                                      words_checked, got));
        end else begin
            want = awaited.pop_front();
            if (got.merge_number  !== want.merge_number)  diffs = {diffs, " merge_number"};
            if (got.left_is_leaf  !== want.left_is_leaf)  diffs = {diffs, " left_is_leaf"};
            if (got.left_id       !== want.left_id)       diffs = {diffs, " left_id"};
            if (got.right_is_leaf !== want.right_is_leaf) diffs = {diffs, " right_is_leaf"};
            if (got.right_id      !== want.right_id)      diffs = {diffs, " right_id"};
            if (got.cluster_size  !== want.cluster_size)  diffs = {diffs, " cluster_size"};
            if (got.skipped       !== want.skipped)       diffs = {diffs, " skipped"};
            if (diffs != "") begin
                report_mismatch($sformatf("result word %0d wrong in%s: got %h, expected %h",
                                          words_checked, diffs, got, want));
            end
        end
    endtask
endclass

module tb_top;
    localparam int CYCLE_LIMIT = 4_000_000;

    logic                        i_clk;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_we    = 1'b0;
    logic [dmb_pkg::CFG_W-1:0]   i_cfg_wdata = '0;
    logic                        i_in_valid  = 1'b0;
    logic [9:0]                  i_leaf_a    = '0;
    logic [9:0]                  i_leaf_b    = '0;
    logic                        i_out_stall = 1'b0;
    logic                        o_in_stall;
    logic                        o_out_valid;
    logic [dmb_pkg::ID_W-1:0]    o_merge_number;
    logic                        o_left_is_leaf;
    logic [dmb_pkg::ID_W-1:0]    o_left_id;
    logic                        o_right_is_leaf;
    logic [dmb_pkg::ID_W-1:0]    o_right_id;
    logic [dmb_pkg::SIZE_W-1:0]  o_cluster_size;
    logic                        o_skipped;

    int              send_gap_pct = 31;
    int              stall_pct    = 59;
    int              cycles       = 0;
    merge_scoreboard merge_log    = new();

    dendrogram_merge_builder_top #(
        .MAX_LEAVES (LEAF_SLOTS),
        .MAX_MERGES (MERGE_SLOTS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_leaf_a        (i_leaf_a),
        .i_leaf_b        (i_leaf_b),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_merge_number  (o_merge_number),
        .o_left_is_leaf  (o_left_is_leaf),
        .o_left_id       (o_left_id),
        .o_right_is_leaf (o_right_is_leaf),
        .o_right_id      (o_right_id),
        .o_cluster_size  (o_cluster_size),
        .o_skipped       (o_skipped)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            merge_log.check_word({o_merge_number, o_left_is_leaf, o_left_id, o_right_is_leaf,
                                  o_right_id, o_cluster_size, o_skipped});
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_edge(input logic [9:0] a, input logic [9:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_leaf_a   <= a;
        i_leaf_b   <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        merge_log.note_edge(a, b);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (merge_log.awaited.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_leaf_count(input int n);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= n[dmb_pkg::CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        merge_log.leaf_limit = n;
    endtask

    task automatic random_edges(input int count);
        int         bound;
        logic [9:0] a;
        logic [9:0] b;
        bound = merge_log.leaf_limit;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0: begin
                    a = 10'($urandom_range(1023));
                    b = 10'($urandom_range(1023));
                end
                1: begin
                    a = 10'($urandom_range(bound - 1));
                    b = a;
                end
                default: begin
                    a = 10'($urandom_range(bound - 1));
                    b = 10'($urandom_range(bound - 1));
                    while (bound > 1 && b == a) b = 10'($urandom_range(bound - 1));
                end
            endcase
            send_edge(a, b);
        end
    endtask

    task automatic random_phase(input int items);
        int done;
        int pick;
        int count;
        done = 0;
        while (done < items) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                write_leaf_count(1);
                count = 4;
            end else if (pick < 9) begin
                write_leaf_count(1024);
                count = 3;
            end else if (pick < 20) begin
                write_leaf_count($urandom_range(700, 65));
                count = 6;
            end else begin
                write_leaf_count($urandom_range(40, 2));
                count = $urandom_range(20, 10);
            end
            random_edges(count);
            done += count;
            if ($urandom_range(3) == 0) begin
                drain_results();
            end
        end
    endtask

    initial begin
        int k;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_edge(10'd1023, 10'd0);
        send_edge(10'd0, 10'd1023);
        send_edge(10'd7, 10'd7);
        write_leaf_count(16);
        send_edge(10'd20, 10'd3);
        send_edge(10'd3, 10'd1023);
        send_edge(10'd0, 10'd15);
        // Leaf 15 keeps a stale label while the bound is 15, so each round double counts
        // and the cluster size climbs into saturation.
        for (int f = 1; f <= 10; f++) begin
            write_leaf_count(15);
            send_edge(10'd0, f[9:0]);
            write_leaf_count(16);
            send_edge(10'd0, 10'd15);
        end

        random_phase(195);
        send_gap_pct = 59;
        stall_pct    = 31;
        random_phase(195);
        send_gap_pct = 0;
        stall_pct    = 0;
        random_phase(190);

        // Fill the merge store with cheap scans, growing the bound just past the next leaf apart from leaf 0.
        k = merge_log.first_leaf_apart();
        while (k > 0 && merge_log.merge_count < MERGE_SLOTS) begin
            write_leaf_count(k + 1);
            send_edge(10'd0, k[9:0]);
            k = merge_log.first_leaf_apart();
        end
        write_leaf_count(1024);
        send_edge(10'd1, 10'd1022);
        send_edge(10'd1023, 10'd512);
        send_edge(10'd0, 10'd1);

        drain_results();
        repeat (1100) @(posedge i_clk);
        if (merge_log.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
